// ----- rtl/assert_macros.svh -----
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("%m failed");
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("%m failed");
`endif

// ----- rtl/rope_pkg.sv -----
`timescale 1ns / 1ps
package rope_pkg;
	localparam int CORDIC_STEPS = 16;
	localparam logic signed [35:0] CORDIC_GAIN = 36'sd652032874;
	localparam int REG_PAIRS = 0;
	localparam int REG_LAYOUT = 1;
	localparam int REG_SCALE = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	function automatic logic signed [35:0] arc_turn(input int i);
		logic signed [35:0] r;
		r = '0;
		case (i)
			0: r = 36'sh020000000;
			1: r = 36'sh012E4051E;
			2: r = 36'sh009FB385B;
			3: r = 36'sh0051111D4;
			4: r = 36'sh0028B0D43;
			5: r = 36'sh00145D7E1;
			6: r = 36'sh000A2F61E;
			7: r = 36'sh000517C55;
			8: r = 36'sh00028BE53;
			9: r = 36'sh000145F2F;
			10: r = 36'sh0000A2F98;
			11: r = 36'sh0000517CC;
			12: r = 36'sh000028BE6;
			13: r = 36'sh0000145F3;
			14: r = 36'sh00000A2FA;
			15: r = 36'sh00000517D;
			default: r = '0;
		endcase
		return r;
	endfunction
endpackage

// ----- rtl/rope_cordic_step.sv -----
`timescale 1ns / 1ps
// one CORDIC rotation step, registered
module rope_cordic_step #(
	parameter int STEP = 0
) (
	input  logic clk,
	input  logic adv,
	input  logic signed [35:0] x_in,
	input  logic signed [35:0] y_in,
	input  logic signed [35:0] z_in,
	output logic signed [35:0] x_s1,
	output logic signed [35:0] y_s1,
	output logic signed [35:0] z_s1
);
	logic signed [35:0] dx, dy;
	assign dx = y_in >>> STEP;
	assign dy = x_in >>> STEP;
	always_ff @(posedge clk) begin
		if (adv) begin
			if (!z_in[35]) begin
				x_s1 <= x_in - dx;
				y_s1 <= y_in + dy;
				z_s1 <= z_in - rope_pkg::arc_turn(STEP);
			end else begin
				x_s1 <= x_in + dx;
				y_s1 <= y_in - dy;
				z_s1 <= z_in + rope_pkg::arc_turn(STEP);
			end
		end
	end
endmodule

// ----- rtl/rotary_position_embedding.sv -----
`timescale 1ns / 1ps
// Rotary position embedding, one pair per cycle unless the output stalls.
// Stages from input accept to result valid: phase multiply,
// fold, 16 CORDIC stages, scale, two rotate stages, round.
// Throughput: one item per cycle; a stall freezes the whole pipeline.
// Reset: asynchronous active low; valid bits clear, config registers to defaults.
module rotary_position_embedding #(
	parameter int MAX_PAIRS = 1024,
	parameter int DATA_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [rope_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rope_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic [15:0] position,
	input  logic [9:0] pair_index,
	input  logic [31:0] frequency,
	input  logic signed [DATA_WIDTH-1:0] first_value,
	input  logic signed [DATA_WIDTH-1:0] second_value,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [DATA_WIDTH-1:0] first_result,
	output logic signed [DATA_WIDTH-1:0] second_result,
	output logic [10:0] first_slot,
	output logic [10:0] second_slot,
	output logic last_in_row
);
	`include "assert_macros.svh"

	localparam int NS = rope_pkg::CORDIC_STEPS;
	// stages: 1 mult, 2 fold, 3..18 cordic, 19 scale, 20 prod, 21 sum, 22 round
	localparam int DEPTH = NS + 6;
	localparam int DW = DATA_WIDTH;
	localparam int PW = DW + 36 + 1;

	typedef struct packed {
		logic [10:0] first_slot;
		logic [10:0] second_slot;
		logic last;
		logic signed [DW-1:0] a;
		logic signed [DW-1:0] b;
	} side_t;

	logic [10:0] pairs_q;
	logic layout_q;
	logic [15:0] scale_q;

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pairs_q <= 11'd64;
			layout_q <= 1'b0;
			scale_q <= 16'd16384;
		end else if (cfg_we) begin
			case (cfg_index)
				2'(rope_pkg::REG_PAIRS): begin
					if (cfg_data[10:0] > 11'(MAX_PAIRS)) pairs_q <= 11'(MAX_PAIRS);
					else pairs_q <= cfg_data[10:0];
				end
				2'(rope_pkg::REG_LAYOUT): layout_q <= cfg_data[0];
				2'(rope_pkg::REG_SCALE): scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline control: whole pipe advances unless output blocked
	logic [DEPTH-1:0] vld_q;
	logic adv;
	assign out_valid = vld_q[DEPTH-1];
	assign adv = !out_valid || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (adv) vld_q <= {vld_q[DEPTH-2:0], in_valid};
	end

	// side data line
	side_t side_in;
	side_t side_q [DEPTH];
	always_comb begin
		side_in.a = first_value;
		side_in.b = second_value;
		side_in.last = (pairs_q != 11'd0) && ({1'b0, pair_index} == pairs_q - 11'd1);
		if (layout_q) begin
			side_in.first_slot = {1'b0, pair_index};
			side_in.second_slot = {1'b0, pair_index} + pairs_q;
		end else begin
			side_in.first_slot = {pair_index, 1'b0};
			side_in.second_slot = {pair_index, 1'b1};
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			side_q[0] <= side_in;
			for (int i = 1; i < DEPTH; i++) side_q[i] <= side_q[i-1];
		end
	end

	// stage 1: phase
	logic [31:0] phase_s1;
	always_ff @(posedge clk) begin
		if (adv) phase_s1 <= 32'(position * frequency);
	end

	// stage 2: fold to +-quarter turn
	logic flip_s2;
	logic signed [35:0] z_s2;
	logic [31:0] fa;
	logic fl;
	assign fl = phase_s1[31] ^ phase_s1[30];
	assign fa = fl ? phase_s1 - 32'h80000000 : phase_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			flip_s2 <= fl;
			z_s2 <= {{4{fa[31]}}, fa};
		end
	end

	logic signed [35:0] xs [NS+1];
	logic signed [35:0] ys [NS+1];
	logic signed [35:0] zs [NS+1];
	logic [NS-1:0] flip_q;
	assign xs[0] = rope_pkg::CORDIC_GAIN;
	assign ys[0] = '0;
	assign zs[0] = z_s2;
	for (genvar g = 0; g < NS; g++) begin : g_cordic
		rope_cordic_step #(.STEP(g)) u_step (
			.clk(clk), .adv(adv),
			.x_in(xs[g]), .y_in(ys[g]), .z_in(zs[g]),
			.x_s1(xs[g+1]), .y_s1(ys[g+1]), .z_s1(zs[g+1])
		);
	end
	always_ff @(posedge clk) begin
		if (adv) flip_q <= {flip_q[NS-2:0], flip_s2};
	end

	// scale stage: c = floor((cos*scale + 2^19) / 2^20)
	logic signed [35:0] cf, sf;
	logic signed [53:0] cm, sm;
	logic signed [33:0] c_s19, s_s19;
	assign cf = flip_q[NS-1] ? -xs[NS] : xs[NS];
	assign sf = flip_q[NS-1] ? -ys[NS] : ys[NS];
	assign cm = cf * $signed({1'b0, scale_q}) + 54'sd524288;
	assign sm = sf * $signed({1'b0, scale_q}) + 54'sd524288;
	always_ff @(posedge clk) begin
		if (adv) begin
			c_s19 <= 34'(cm >>> 20);
			s_s19 <= 34'(sm >>> 20);
		end
	end

	// products
	logic signed [PW-1:0] ac_s20, bs_s20, as_s20, bc_s20;
	side_t sd19;
	assign sd19 = side_q[NS+2];
	always_ff @(posedge clk) begin
		if (adv) begin
			ac_s20 <= PW'(sd19.a * c_s19);
			bs_s20 <= PW'(sd19.b * s_s19);
			as_s20 <= PW'(sd19.a * s_s19);
			bc_s20 <= PW'(sd19.b * c_s19);
		end
	end

	// sums with rounding offset of one half (2^23)
	logic signed [PW:0] r0_s21, r1_s21;
	always_ff @(posedge clk) begin
		if (adv) begin
			r0_s21 <= (PW+1)'(ac_s20) - (PW+1)'(bs_s20) + (PW+1)'(25'sd8388608);
			r1_s21 <= (PW+1)'(as_s20) + (PW+1)'(bc_s20) + (PW+1)'(25'sd8388608);
		end
	end

	// round and saturate
	function automatic logic signed [DW-1:0] sat(input logic signed [PW:0] v);
		logic signed [PW:0] t;
		logic signed [PW:0] hi, lo;
		t = v >>> 24;
		hi = (PW+1)'((64'sd1 <<< (DW-1)) - 64'sd1);
		lo = -hi - 1;
		if (t > hi) return hi[DW-1:0];
		if (t < lo) return lo[DW-1:0];
		return t[DW-1:0];
	endfunction

	always_ff @(posedge clk) begin
		if (adv) begin
			first_result <= sat(r0_s21);
			second_result <= sat(r1_s21);
		end
	end

	side_t sd_out;
	assign sd_out = side_q[DEPTH-1];
	assign first_slot = sd_out.first_slot;
	assign second_slot = sd_out.second_slot;
	assign last_in_row = sd_out.last;

	`ASSERT_NEXT(a_stall_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`ASSERT_IMPL(a_ready_free, clk, arst_n, !out_valid, in_ready)
	`ASSERT_NEXT(a_no_spurious, clk, arst_n, adv && !vld_q[DEPTH-2], !out_valid)
endmodule
